/* rtl/core/phbf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phbf_pkg: shared types and constants for the packet header blocklist filter
// Request and result structs, table sizes, request and outcome codes.
// ----------------------------------------------------------------------------
package phbf_pkg;

    localparam int MAC_ENTRIES  = 256;
    localparam int IPV4_ENTRIES = 512;
    localparam int IPV6_ENTRIES = 256;
    localparam int MAC_AW  = $clog2(MAC_ENTRIES);
    localparam int IPV4_AW = $clog2(IPV4_ENTRIES);
    localparam int IPV6_AW = $clog2(IPV6_ENTRIES);
    localparam int SCAN_W  = 10;
    localparam int CAP_BYTES = 74;
    localparam int CAP_AW    = 7;

    localparam logic [1:0] REQ_BYTE = 2'd0;
    localparam logic [1:0] REQ_MAC  = 2'd1;
    localparam logic [1:0] REQ_IPV4 = 2'd2;
    localparam logic [1:0] REQ_IPV6 = 2'd3;

    localparam logic [2:0] OUT_PASS  = 3'd0;
    localparam logic [2:0] OUT_SHORT = 3'd1;
    localparam logic [2:0] OUT_DMAC  = 3'd2;
    localparam logic [2:0] OUT_DIPV4 = 3'd3;
    localparam logic [2:0] OUT_DIPV6 = 3'd4;

    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  data_byte;
        logic        last;
        logic [8:0]  entry_index;
        logic        entry_valid;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
    } phbf_req_t;

    typedef struct packed {
        logic [2:0]  outcome;
        logic [47:0] source_mac;
        logic [47:0] dest_mac;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [63:0] src_addr_hi;
        logic [63:0] src_addr_lo;
        logic [63:0] dst_addr_hi;
        logic [63:0] dst_addr_lo;
        logic [15:0] l4_sport;
        logic [15:0] l4_dport;
        logic [15:0] frame_len;
    } phbf_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic clr_step;    // clear one table slot after reset
        logic take;        // accept input request
        logic scan_clear;  // reset scan index and hit flags
        logic scan_step;   // examine one table slot
        logic emit;        // load output register
    } phbf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;    // clearing the final table slot
        logic is_final;    // accepted request is a last packet byte
        logic scan_done;   // all slots examined
    } phbf_sts_t;

endpackage : phbf_pkg
`default_nettype wire

/* rtl/core/phbf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phbf_datapath: capture, tables, lookup scan and result register
// Captures header bytes, holds the three blocklists in memories (cleared by a
// pass after reset), scans them one slot per cycle after the final byte and
// builds the result.
// ----------------------------------------------------------------------------
module phbf_datapath
    import phbf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire phbf_req_t req,
    input  wire phbf_cmd_t cmd,
    output phbf_sts_t      sts,
    output phbf_rsp_t      rsp
);

    logic [7:0]  cap_mem [CAP_BYTES];
    logic [48:0] mac_mem  [MAC_ENTRIES];
    logic [32:0] ipv4_mem [IPV4_ENTRIES];
    logic [64:0] ipv6_lo_mem [IPV6_ENTRIES];
    logic [63:0] ipv6_hi_mem [IPV6_ENTRIES];

    logic [15:0] offset_reg, offset_next;
    logic [15:0] size_reg;
    logic [SCAN_W-1:0] clr_reg;
    logic [SCAN_W-1:0] scan_reg;
    logic [SCAN_W-1:0] scan_d_reg;
    logic        rd_vld_reg;
    logic        mac_hit_reg, ipv4_hit_reg, ipv6_hit_reg;
    logic [48:0] mac_rd_reg;
    logic [32:0] ipv4_rd_reg;
    logic [64:0] ipv6_lo_rd_reg;
    logic [63:0] ipv6_hi_rd_reg;
    phbf_rsp_t   rsp_reg, rsp_next;

    logic [111:0] hdr_a;   // bytes 0..13
    logic [63:0]  v6_src_hi, v6_src_lo, v6_dst_hi, v6_dst_lo;
    logic [31:0]  v4_src, v4_dst;

    wire logic pkt_byte = cmd.take && req.req_type == REQ_BYTE;

    always_comb
    begin
        offset_next = offset_reg;
        if (pkt_byte)
        begin
            if (req.last)
                offset_next = '0;
            else if (offset_reg != 16'hFFFF)
                offset_next = offset_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            clr_reg    <= '0;
        end
        else
        begin
            offset_reg <= offset_next;
            if (cmd.clr_step)
                clr_reg <= clr_reg + SCAN_W'(1);
        end
    end

    // Byte capture, table writes and size of the finished packet: counted byte plus saturation
    always_ff @(posedge clk)
    begin
        if (pkt_byte)
        begin
            if (offset_reg < 16'(CAP_BYTES))
                cap_mem[offset_reg[CAP_AW-1:0]] <= req.data_byte;
            if (req.last)
                size_reg <= (offset_reg == 16'hFFFF) ? offset_reg : offset_reg + 16'd1;
        end
        // clearing pass after reset: one slot of each table per cycle
        if (cmd.clr_step)
        begin
            if (clr_reg < SCAN_W'(MAC_ENTRIES))
                mac_mem[clr_reg[MAC_AW-1:0]] <= '0;
            if (clr_reg < SCAN_W'(IPV4_ENTRIES))
                ipv4_mem[clr_reg[IPV4_AW-1:0]] <= '0;
            if (clr_reg < SCAN_W'(IPV6_ENTRIES))
                ipv6_lo_mem[clr_reg[IPV6_AW-1:0]] <= '0;
        end
        else
        begin
            if (cmd.take && req.req_type == REQ_MAC && req.entry_index < 9'(MAC_ENTRIES))
                mac_mem[req.entry_index[MAC_AW-1:0]] <= {req.entry_valid, req.key_lo[47:0]};
            if (cmd.take && req.req_type == REQ_IPV4
                && {1'b0, req.entry_index} < 10'(IPV4_ENTRIES))
                ipv4_mem[req.entry_index[IPV4_AW-1:0]] <= {req.entry_valid, req.key_lo[31:0]};
            if (cmd.take && req.req_type == REQ_IPV6 && req.entry_index < 9'(IPV6_ENTRIES))
            begin
                ipv6_lo_mem[req.entry_index[IPV6_AW-1:0]] <= {req.entry_valid, req.key_lo};
                ipv6_hi_mem[req.entry_index[IPV6_AW-1:0]] <= req.key_hi;
            end
        end
        // registered reads, one slot per cycle
        mac_rd_reg     <= mac_mem[scan_reg[MAC_AW-1:0]];
        ipv4_rd_reg    <= ipv4_mem[scan_reg[IPV4_AW-1:0]];
        ipv6_lo_rd_reg <= ipv6_lo_mem[scan_reg[IPV6_AW-1:0]];
        ipv6_hi_rd_reg <= ipv6_hi_mem[scan_reg[IPV6_AW-1:0]];
    end

    always_comb
    begin
        for (int i = 0; i < 14; i++)
            hdr_a[111-8*i -: 8] = cap_mem[i];
        for (int i = 0; i < 4; i++)
        begin
            v4_src[31-8*i -: 8] = cap_mem[26+i];
            v4_dst[31-8*i -: 8] = cap_mem[30+i];
        end
        for (int i = 0; i < 8; i++)
        begin
            v6_src_hi[63-8*i -: 8] = cap_mem[22+i];
            v6_src_lo[63-8*i -: 8] = cap_mem[30+i];
            v6_dst_hi[63-8*i -: 8] = cap_mem[38+i];
            v6_dst_lo[63-8*i -: 8] = cap_mem[46+i];
        end
    end

    // Scan: the read data belongs to the index of the cycle before, kept in scan_d_reg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg     <= '0;
            scan_d_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            mac_hit_reg  <= 1'b0;
            ipv4_hit_reg <= 1'b0;
            ipv6_hit_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            scan_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            mac_hit_reg  <= 1'b0;
            ipv4_hit_reg <= 1'b0;
            ipv6_hit_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (scan_reg != SCAN_W'(IPV4_ENTRIES))
                scan_reg <= scan_reg + SCAN_W'(1);
            scan_d_reg <= scan_reg;
            rd_vld_reg <= scan_reg != SCAN_W'(IPV4_ENTRIES);
            if (rd_vld_reg)
            begin
                if (scan_d_reg < SCAN_W'(MAC_ENTRIES) && mac_rd_reg[48]
                    && mac_rd_reg[47:0] == hdr_a[63:16])
                    mac_hit_reg <= 1'b1;
                if (scan_d_reg < SCAN_W'(IPV4_ENTRIES)
                    && ipv4_rd_reg[32] && ipv4_rd_reg[31:0] == v4_src)
                    ipv4_hit_reg <= 1'b1;
                if (scan_d_reg < SCAN_W'(IPV6_ENTRIES) && ipv6_lo_rd_reg[64]
                    && ipv6_lo_rd_reg[63:0] == v6_src_lo && ipv6_hi_rd_reg == v6_src_hi)
                    ipv6_hit_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        sts.clr_last  = clr_reg == SCAN_W'(IPV4_ENTRIES - 1);
        sts.is_final  = req.req_type == REQ_BYTE && req.last;
        sts.scan_done = scan_reg == SCAN_W'(IPV4_ENTRIES) && !rd_vld_reg;
    end

    always_comb
    begin
        logic [15:0] et;
        logic [7:0]  proto;
        logic [15:0] thoff;
        logic [15:0] tp_src, tp_dst;
        et = hdr_a[15:0];
        proto = '0;
        thoff = '0;
        tp_src = '0;
        tp_dst = '0;
        rsp_next = '0;
        if (size_reg < 16'd14)
            rsp_next.outcome = OUT_SHORT;
        else if (mac_hit_reg)
        begin
            rsp_next.outcome    = OUT_DMAC;
            rsp_next.source_mac = hdr_a[63:16];
        end
        else
        begin
            rsp_next.outcome    = OUT_PASS;
            rsp_next.source_mac = hdr_a[63:16];
            rsp_next.dest_mac   = hdr_a[111:64];
            rsp_next.ether_type = et;
            rsp_next.frame_len  = size_reg;
            if (et == ETH_IPV4 && size_reg >= 16'd34)
            begin
                rsp_next.src_addr_lo = {32'd0, v4_src};
                rsp_next.dst_addr_lo = {32'd0, v4_dst};
                if (ipv4_hit_reg)
                    rsp_next.outcome = OUT_DIPV4;
                else
                begin
                    proto = cap_mem[23];
                    thoff = 16'd34;
                    tp_src = {cap_mem[34], cap_mem[35]};
                    tp_dst = {cap_mem[36], cap_mem[37]};
                    rsp_next.ip_protocol = proto;
                end
            end
            else if (et == ETH_IPV6 && size_reg >= 16'd54)
            begin
                rsp_next.src_addr_hi = v6_src_hi;
                rsp_next.src_addr_lo = v6_src_lo;
                rsp_next.dst_addr_hi = v6_dst_hi;
                rsp_next.dst_addr_lo = v6_dst_lo;
                if (ipv6_hit_reg)
                    rsp_next.outcome = OUT_DIPV6;
                else
                begin
                    proto = cap_mem[20];
                    thoff = 16'd54;
                    tp_src = {cap_mem[54], cap_mem[55]};
                    tp_dst = {cap_mem[56], cap_mem[57]};
                    rsp_next.ip_protocol = proto;
                end
            end
            if (thoff != 16'd0 && ((proto == PROTO_TCP && size_reg >= thoff + 16'd20)
                || (proto == PROTO_UDP && size_reg >= thoff + 16'd8)))
            begin
                rsp_next.l4_sport = tp_src;
                rsp_next.l4_dport = tp_dst;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

`ifndef ASSERT_OFF
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg <= SCAN_W'(IPV4_ENTRIES))
        else $error("scan index out of range");
    a_offset_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_byte && req.last |=> offset_reg == 16'd0)
        else $error("byte count not cleared after last byte");
    a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_clear |=> !sts.scan_done)
        else $error("scan done right after clear");
`endif

endmodule : phbf_datapath
`default_nettype wire

/* rtl/core/phbf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phbf_ctrl: request sequencing for the header blocklist filter
// Clears the tables after reset, accepts requests, runs the table scan after
// a final byte and hands the result to the output register.
// ----------------------------------------------------------------------------
module phbf_ctrl
    import phbf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire phbf_sts_t sts,
    output phbf_cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_INIT = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (sts.is_final)
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the previous result has left
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef ASSERT_OFF
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !out_valid_reg || !out_stall)
        else $error("result overwritten while stalled");
    a_scan_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && sts.scan_done |=> state_reg == ST_OUT)
        else $error("scan end not followed by output");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> state_reg == ST_IDLE)
        else $error("request taken outside idle");
`endif

endmodule : phbf_ctrl
`default_nettype wire

/* rtl/core/packet_header_blocklist_filter.sv */
`default_nettype none
// A byte or table write is taken as soon as it is offered while idle; for a final
// byte the result is offered after a scan of every slot of the largest blocklist
// (512 slots, one slot per cycle, through a read register) and an output state.
// Requests are taken one per cycle while idle; after a final byte the input stalls
// until the result is loaded, and longer while a stalled result waits.
// Reset: asynchronous; then input stalls for a pass that invalidates all slots.
// ----------------------------------------------------------------------------
// packet_header_blocklist_filter: Ethernet/IP header parser with blocklists
// Parses headers of a byte stream and drops packets by source MAC or IP.
// ----------------------------------------------------------------------------
module packet_header_blocklist_filter
    import phbf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire phbf_req_t in_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output phbf_rsp_t      out_data
);

    phbf_cmd_t cmd;
    phbf_sts_t sts;

    phbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    phbf_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (out_data)
    );

endmodule : packet_header_blocklist_filter
`default_nettype wire
